>>> sv/pcj_pkg.sv
// ----------------------------------------------------------------------------
// pcj_pkg
// Shared types and constants for the pixel canvas undo/redo journal.
// ----------------------------------------------------------------------------
package pcj_pkg;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 64;
    localparam int HISTORY_DEPTH = 256;
    localparam int STORE_DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW            = $clog2(STORE_DEPTH);
    localparam int HW            = $clog2(HISTORY_DEPTH);
    localparam int CW            = 6;
    localparam int REGW          = 7;

    localparam logic [31:0] ERASE_COLOUR = 32'h00ff_ffff;

    localparam logic [2:0] MODE_READ  = 3'd0;
    localparam logic [2:0] MODE_DRAW  = 3'd1;
    localparam logic [2:0] MODE_ERASE = 3'd2;
    localparam logic [2:0] MODE_RECT  = 3'd3;
    localparam logic [2:0] MODE_UNDO  = 3'd4;
    localparam logic [2:0] MODE_REDO  = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [31:0]   colour;
    } jentry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic clr_step;   // clearing sweep write
        logic rd_issue;   // issue journal/pixel reads for current op
        logic wr_commit;  // perform the write and journal update
        logic rect_adv;   // step rectangle cursor
        logic out_load;   // load result register
    } pcj_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic rect_last;
        logic is_rect;
        logic is_write;   // op performs a pixel write
        logic [1:0] early_status;
    } pcj_sts_t;

endpackage

>>> sv/pcj_datapath.sv
// ----------------------------------------------------------------------------
// pcj_datapath
// Canvas memory, journals, rectangle cursor and result register.
// ----------------------------------------------------------------------------
module pcj_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcj_pkg::pcj_cmd_t       cmd,
    output pcj_pkg::pcj_sts_t       sts,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [pcj_pkg::REGW-1:0] cfg_data,
    input  logic [2:0]              mode,
    input  logic [pcj_pkg::CW-1:0]  x_start,
    input  logic [pcj_pkg::CW-1:0]  y_start,
    input  logic [pcj_pkg::CW-1:0]  x_end,
    input  logic [pcj_pkg::CW-1:0]  y_end,
    input  logic [31:0]             color,
    output logic [1:0]              status,
    output logic [31:0]             pixel_value
);

    localparam int AW = pcj_pkg::AW;
    localparam int HW = pcj_pkg::HW;
    localparam int CW = pcj_pkg::CW;
    localparam int RW = pcj_pkg::REGW;

    logic [31:0]         pix_mem [pcj_pkg::STORE_DEPTH];
    pcj_pkg::jentry_t    undo_mem [pcj_pkg::HISTORY_DEPTH];
    pcj_pkg::jentry_t    redo_mem [pcj_pkg::HISTORY_DEPTH];

    logic [RW-1:0] rows_reg, cols_reg;
    logic [AW:0]   clr_reg;
    logic [2:0]    mode_reg;
    logic [CW-1:0] xs_reg, ys_reg, xe_reg, ye_reg, cx_reg, cy_reg;
    logic [31:0]   colour_reg;
    logic [HW-1:0] uold_reg;
    logic [HW:0]   ucnt_reg, rcnt_reg;
    logic [31:0]   pix_q;
    pcj_pkg::jentry_t uq, rq;
    logic [1:0]    st_reg;
    logic [1:0]    est_reg;
    logic [31:0]   val_reg;

    logic [RW-1:0] erows, ecols;
    logic [CW-1:0] ax, ay;
    logic [AW-1:0] addr;
    logic [AW+RW:0] prod;
    logic          start_ok, end_ok;
    logic [HW-1:0] utop, uslot;
    logic [1:0]    est;
    pcj_pkg::jentry_t src;

    always_comb
    begin
        erows = (rows_reg == '0) ? RW'(1)
              : (rows_reg > RW'(pcj_pkg::MAX_ROWS)) ? RW'(pcj_pkg::MAX_ROWS) : rows_reg;
        ecols = (cols_reg == '0) ? RW'(1)
              : (cols_reg > RW'(pcj_pkg::MAX_COLS)) ? RW'(pcj_pkg::MAX_COLS) : cols_reg;
        start_ok = ({1'b0, xs_reg} < ecols) && ({1'b0, ys_reg} < erows);
        end_ok   = ({1'b0, xe_reg} < ecols) && ({1'b0, ye_reg} < erows);
        case (mode_reg)
            pcj_pkg::MODE_UNDO: src = uq;
            pcj_pkg::MODE_REDO: src = rq;
            default:
            begin
                src.x = cx_reg;
                src.y = cy_reg;
                src.colour = colour_reg;
            end
        endcase
        if (mode_reg == pcj_pkg::MODE_UNDO || mode_reg == pcj_pkg::MODE_REDO)
        begin
            ax = src.x;
            ay = src.y;
        end
        else
        begin
            ax = cx_reg;
            ay = cy_reg;
        end
        prod = (AW+RW+1)'(ay) * (AW+RW+1)'(ecols) + (AW+RW+1)'(ax);
        addr = prod[AW-1:0];
        utop  = uold_reg + ucnt_reg[HW-1:0] - HW'(1);
        uslot = uold_reg + ucnt_reg[HW-1:0];
        est = pcj_pkg::ST_DONE;
        case (mode_reg)
            pcj_pkg::MODE_READ, pcj_pkg::MODE_DRAW, pcj_pkg::MODE_ERASE:
                if (!start_ok) est = pcj_pkg::ST_RANGE;
            pcj_pkg::MODE_RECT:
                if (!start_ok || !end_ok) est = pcj_pkg::ST_RANGE;
            pcj_pkg::MODE_UNDO:
                if (ucnt_reg == '0) est = pcj_pkg::ST_EMPTY;
            pcj_pkg::MODE_REDO:
                if (rcnt_reg == '0) est = pcj_pkg::ST_EMPTY;
            default: est = pcj_pkg::ST_DONE;
        endcase
        sts.early_status = est;
        sts.is_rect  = (mode_reg == pcj_pkg::MODE_RECT);
        sts.is_write = (est == pcj_pkg::ST_DONE) &&
                       (mode_reg == pcj_pkg::MODE_DRAW || mode_reg == pcj_pkg::MODE_ERASE ||
                        mode_reg == pcj_pkg::MODE_UNDO || mode_reg == pcj_pkg::MODE_REDO ||
                        (mode_reg == pcj_pkg::MODE_RECT && ys_reg <= ye_reg &&
                         xs_reg <= xe_reg));
        sts.rect_last = (cx_reg == xe_reg) && (cy_reg == ye_reg);
        sts.clr_last  = (clr_reg == (AW+1)'(pcj_pkg::STORE_DEPTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RW'(pcj_pkg::MAX_ROWS);
            cols_reg <= RW'(pcj_pkg::MAX_COLS);
            clr_reg  <= '0;
            uold_reg <= '0;
            ucnt_reg <= '0;
            rcnt_reg <= '0;
            st_reg   <= pcj_pkg::ST_DONE;
            est_reg  <= pcj_pkg::ST_DONE;
            val_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pcj_pkg::REG_ROWS) rows_reg <= cfg_data;
                else                                cols_reg <= cfg_data;
            end
            if (cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            // status fixed before the journal counts move
            if (cmd.rd_issue) est_reg <= est;
            if (cmd.wr_commit)
            begin
                case (mode_reg)
                    pcj_pkg::MODE_UNDO:
                    begin
                        ucnt_reg <= ucnt_reg - 1'b1;
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                    default:
                    begin
                        if (ucnt_reg == (HW+1)'(pcj_pkg::HISTORY_DEPTH))
                            uold_reg <= uold_reg + 1'b1;
                        else
                            ucnt_reg <= ucnt_reg + 1'b1;
                        if (mode_reg == pcj_pkg::MODE_REDO)
                            rcnt_reg <= rcnt_reg - 1'b1;
                    end
                endcase
            end
            if (cmd.out_load)
            begin
                st_reg  <= est_reg;
                val_reg <= (mode_reg == pcj_pkg::MODE_READ && est_reg == pcj_pkg::ST_DONE)
                           ? pix_q : 32'd0;
                if (est_reg == pcj_pkg::ST_DONE && (mode_reg == pcj_pkg::MODE_DRAW ||
                    mode_reg == pcj_pkg::MODE_ERASE || mode_reg == pcj_pkg::MODE_RECT))
                    rcnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            xs_reg     <= x_start;
            ys_reg     <= y_start;
            xe_reg     <= x_end;
            ye_reg     <= y_end;
            cx_reg     <= x_start;
            cy_reg     <= y_start;
            colour_reg <= (mode == pcj_pkg::MODE_ERASE) ? pcj_pkg::ERASE_COLOUR : color;
        end
        else if (cmd.rect_adv)
        begin
            if (cx_reg == xe_reg)
            begin
                cx_reg <= xs_reg;
                cy_reg <= cy_reg + 1'b1;
            end
            else
                cx_reg <= cx_reg + 1'b1;
        end
        if (cmd.rd_issue)
        begin
            uq <= undo_mem[utop];
            rq <= redo_mem[rcnt_reg[HW-1:0] - HW'(1)];
        end
    end

    // canvas: one port, read registered, write by sweep or commit
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            pix_mem[clr_reg[AW-1:0]] <= '0;
        else if (cmd.wr_commit)
            pix_mem[addr] <= src.colour;
        pix_q <= pix_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_commit && mode_reg != pcj_pkg::MODE_UNDO)
            undo_mem[(ucnt_reg == (HW+1)'(pcj_pkg::HISTORY_DEPTH)) ? uold_reg : uslot]
                <= '{x: ax, y: ay, colour: pix_q};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_commit && mode_reg == pcj_pkg::MODE_UNDO)
            redo_mem[rcnt_reg[HW-1:0]] <= '{x: ax, y: ay, colour: pix_q};
    end

    assign status      = st_reg;
    assign pixel_value = val_reg;

endmodule

>>> sv/pcj_ctrl.sv
// ----------------------------------------------------------------------------
// pcj_ctrl
// Sequencer: clearing sweep, journal fetch, read-modify-write, result hand-off.
// ----------------------------------------------------------------------------
module pcj_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output pcj_pkg::pcj_cmd_t   cmd,
    input  pcj_pkg::pcj_sts_t   sts
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_ADDR, S_READ, S_WRITE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (out_valid && out_ready) ov_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_ADDR;
            end
            S_ADDR:
                state_next = S_READ;
            S_READ:
                state_next = sts.is_write ? S_WRITE : S_OUT;
            S_WRITE:
            begin
                cmd.wr_commit = 1'b1;
                if (sts.is_rect && !sts.rect_last)
                begin
                    cmd.rect_adv = 1'b1;
                    state_next   = S_ADDR;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

>>> sv/pixel_canvas_undo_redo_journal.sv
// ----------------------------------------------------------------------------
// pixel_canvas_undo_redo_journal
// Pixel canvas store with per-pixel undo and redo journals.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one command transaction; output
// channel (out_valid/out_ready) returns exactly one status/pixel_value
// transaction per command, in order.
// Each command passes through fetch, address, read, write and result states;
// a read skips the write state, and a rectangle repeats the address, read
// and write states for every pixel (one journal-pushing read-modify-write
// of the single-port canvas memory per pixel). Rejected commands, empty
// journals, empty rectangles and unused modes also skip the write state. One
// command is in flight at a time; the next can be accepted in the cycle after
// the result is loaded. After reset the canvas memory is swept to zero,
// during which in_ready stays low; configuration writes are taken at any time.
// The result sits in an output register; a stalled receiver holds it, and
// the next command is accepted but its result waits until that register
// has been taken.
// Configuration: cfg_we, cfg_index (0 rows, 1 columns), cfg_data.
// ----------------------------------------------------------------------------
module pixel_canvas_undo_redo_journal
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [5:0]  x_start,
    input  logic [5:0]  y_start,
    input  logic [5:0]  x_end,
    input  logic [5:0]  y_end,
    input  logic [31:0] color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] pixel_value
);

    pcj_pkg::pcj_cmd_t cmd;
    pcj_pkg::pcj_sts_t sts;

    pcj_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pcj_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .color       (color),
        .status      (status),
        .pixel_value (pixel_value)
    );

endmodule

>>> sv/pcj_checker.sv
// ----------------------------------------------------------------------------
// pcj_checker
// Port-level checks for the canvas journal.
// ----------------------------------------------------------------------------
module pcj_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] pixel_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pixel_value))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'd0 |-> pixel_value == 32'd0)
        else $error("nonzero value on failed transaction");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken immediately");

endmodule

bind pixel_canvas_undo_redo_journal pcj_checker u_pcj_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pixel_value (pixel_value)
);
